// ===== rtl/core/axis_angle_vector_rotation_unit_assert.svh =====
// Assertion macros for the axis-angle vector rotation unit
`ifndef AXIS_ANGLE_VECTOR_ROTATION_UNIT_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define AAVR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aavr assertion failed");
`define AAVR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("aavr assertion failed");
`else
`define AAVR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AAVR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/aavr_pkg.sv =====
// Shared types and constants for the axis-angle vector rotation unit
package aavr_pkg;
  localparam int ONE_Q15 = 32768;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int SINE_TERMS = 12;
  localparam int ENT_W = 18;
  localparam int VEC_W = 32;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_ANGLE  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_AXIS_X = 3'd1;
  localparam logic [CFG_AW-1:0] REG_AXIS_Y = 3'd2;
  localparam logic [CFG_AW-1:0] REG_AXIS_Z = 3'd3;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef ent_t [8:0] mat_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
  } lane_ctl_t;
endpackage

// ===== rtl/core/aavr_trig.sv =====
// Sine table and sequencer that rebuilds the rotation matrix after a register write
module aavr_trig #(
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [aavr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [aavr_pkg::CFG_DW-1:0] cfg_data,
  output aavr_pkg::mat_t             mat,
  output logic                       busy
);
  import aavr_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FW = ANGLE_BITS - 2;
  localparam int PW = FW + IW;
  localparam int SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SHR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDS   = 3'd1;
  localparam logic [2:0] ST_RDC   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_UU    = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;

  // Taylor term divisors (2n+2)(2n+3)
  localparam longint unsigned TERM_DIV [SINE_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [15:0] tab_t [0:SINE_TABLE_DEPTH];

  function automatic tab_t build_tab();
    tab_t t;
    longint unsigned x, x2, term;
    longint sum, r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (PI_HALF_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = 0;
      for (int n = 0; n < SINE_TERMS; n++) begin
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
        term = ((term * x2) >> 30) / TERM_DIV[n];
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r < 0) r = 0;
      if (r > ONE_Q15) r = ONE_Q15;
      t[k] = 16'(r);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  logic [15:0]          angle_r;
  logic signed [15:0]   ux_r, uy_r, uz_r;
  logic [2:0]           state_r;
  logic [3:0]           ent_r;
  logic [15:0]          rom_q_r;
  logic [IW-1:0]        rom_addr;
  logic signed [16:0]   s_r, c_r;
  logic signed [17:0]   sx_r, sy_r, sz_r;
  logic signed [31:0]   uu_r;
  mat_t                 mat_r;

  logic [ANGLE_BITS-1:0] ps, pc, pr;
  logic [FW-1:0]         fr;
  logic [PW-1:0]         iprod;
  logic [IW-1:0]         idx;
  logic signed [16:0]    tab_val;
  logic                  cfg_hit;
  logic signed [15:0]    ui, uj;
  logic signed [17:0]    om;
  logic signed [49:0]    uuom;
  logic signed [19:0]    uuom_r, sterm, ent_sum;
  logic signed [32:0]    sxp, syp, szp;

  assign ps = ANGLE_BITS'((32'(angle_r) << SHL) >> SHR);
  assign pc = ps + {2'b01, {FW{1'b0}}};
  assign pr = (state_r == ST_RDS) ? ps : pc;
  assign fr = pr[FW-1:0];
  assign iprod = PW'(fr) * PW'(SINE_TABLE_DEPTH);
  assign idx = IW'(iprod >> FW);
  assign rom_addr = pr[FW] ? IW'(SINE_TABLE_DEPTH) - idx : idx;

  // sign from the quadrant of the phase read in the previous cycle
  always_comb begin
    if (state_r == ST_RDC) tab_val = ps[ANGLE_BITS-1] ? -$signed({1'b0, rom_q_r})
                                                       : $signed({1'b0, rom_q_r});
    else tab_val = pc[ANGLE_BITS-1] ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
  end

  assign cfg_hit = cfg_we && (cfg_addr == REG_ANGLE || cfg_addr == REG_AXIS_X ||
                              cfg_addr == REG_AXIS_Y || cfg_addr == REG_AXIS_Z);

  always_comb begin
    case (ent_r)
      4'd0: begin ui = ux_r; uj = ux_r; sterm = 20'(c_r); end
      4'd1: begin ui = ux_r; uj = uy_r; sterm = -20'(sz_r); end
      4'd2: begin ui = ux_r; uj = uz_r; sterm = 20'(sy_r); end
      4'd3: begin ui = uy_r; uj = ux_r; sterm = 20'(sz_r); end
      4'd4: begin ui = uy_r; uj = uy_r; sterm = 20'(c_r); end
      4'd5: begin ui = uy_r; uj = uz_r; sterm = -20'(sx_r); end
      4'd6: begin ui = uz_r; uj = ux_r; sterm = -20'(sy_r); end
      4'd7: begin ui = uz_r; uj = uy_r; sterm = 20'(sx_r); end
      default: begin ui = uz_r; uj = uz_r; sterm = 20'(c_r); end
    endcase
  end

  assign om = 18'sd32768 - 18'(c_r);
  assign uuom = 50'(uu_r) * 50'(om);
  assign uuom_r = 20'((uuom + 50'sd536870912) >>> 30);
  assign ent_sum = uuom_r + sterm;
  assign sxp = 33'(ux_r) * 33'(s_r);
  assign syp = 33'(uy_r) * 33'(s_r);
  assign szp = 33'(uz_r) * 33'(s_r);

  always_ff @(posedge clk) begin
    rom_q_r <= SIN_TAB[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      ux_r <= 16'sd32767;
      uy_r <= '0;
      uz_r <= '0;
      state_r <= ST_IDLE;
      ent_r <= '0;
      for (int e = 0; e < 9; e++) mat_r[e] <= (e % 4 == 0) ? ENT_W'(ONE_Q15) : '0;
    end else if (cfg_hit) begin
      case (cfg_addr)
        REG_ANGLE:  angle_r <= cfg_data;
        REG_AXIS_X: ux_r <= cfg_data;
        REG_AXIS_Y: uy_r <= cfg_data;
        default:    uz_r <= cfg_data;
      endcase
      state_r <= ST_RDS;
    end else begin
      case (state_r)
        ST_RDS: state_r <= ST_RDC;
        ST_RDC: begin
          s_r <= tab_val;
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          c_r <= tab_val;
          sx_r <= 18'((sxp + 33'sd16384) >>> 15);
          sy_r <= 18'((syp + 33'sd16384) >>> 15);
          sz_r <= 18'((szp + 33'sd16384) >>> 15);
          ent_r <= '0;
          state_r <= ST_UU;
        end
        ST_UU: begin
          uu_r <= 32'(ui) * 32'(uj);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          mat_r[ent_r] <= ENT_W'(ent_sum);
          if (ent_r == 4'd8) state_r <= ST_IDLE;
          else begin
            ent_r <= ent_r + 4'd1;
            state_r <= ST_UU;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign mat = mat_r;
  assign busy = cfg_we || (state_r != ST_IDLE);
endmodule

// ===== rtl/core/aavr_lane.sv =====
// One matrix row times the point: products, rounding and saturation
module aavr_lane (
  input  logic                             clk,
  input  aavr_pkg::lane_ctl_t              ctl,
  input  aavr_pkg::ent_t                   m0,
  input  aavr_pkg::ent_t                   m1,
  input  aavr_pkg::ent_t                   m2,
  input  logic signed [aavr_pkg::VEC_W-1:0] v0,
  input  logic signed [aavr_pkg::VEC_W-1:0] v1,
  input  logic signed [aavr_pkg::VEC_W-1:0] v2,
  output logic signed [aavr_pkg::VEC_W-1:0] res,
  output logic                             ovf
);
  import aavr_pkg::*;

  logic signed [49:0] p0_r, p1_r, p2_r;
  logic signed [51:0] acc;
  logic signed [36:0] rnd;
  logic signed [VEC_W-1:0] res_r;
  logic ovf_r;

  assign acc = 52'(p0_r) + 52'(p1_r) + 52'(p2_r);
  assign rnd = 37'((acc + 52'sd16384) >>> 15);

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      p0_r <= 50'(m0) * 50'(v0);
      p1_r <= 50'(m1) * 50'(v1);
      p2_r <= 50'(m2) * 50'(v2);
    end
    if (ctl.adv2) begin
      if (rnd > 37'sd2147483647) begin
        res_r <= 32'sh7fffffff;
        ovf_r <= 1'b1;
      end else if (rnd < -37'sd2147483648) begin
        res_r <= 32'sh80000000;
        ovf_r <= 1'b1;
      end else begin
        res_r <= 32'(rnd);
        ovf_r <= 1'b0;
      end
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;
endmodule

// ===== rtl/core/axis_angle_vector_rotation_unit.sv =====
// Top level of the axis-angle vector rotation unit
// Rotates Q16.16 points about a unit axis (Q1.15) by an angle (2*pi/65536 units).
// Channels: in_* carries one point per item, out_* one rotated point plus an
// overflow flag set when any component saturated. Both use valid/stall.
// Configuration: cfg_we/cfg_addr/cfg_data write angle (0), axis x/y/z (1..3).
// Each write to these registers restarts the matrix rebuild (sine and cosine
// table reads, scaling, then one product and accumulate per entry), during which in_stall is high.
// Throughput: one item per cycle once the matrix is built, while out_stall is low.
// Stages from acceptance to out_valid: product, round/saturate, merge
// register; the three lanes compute one matrix row each.
// Reset: axis (1,0,0), angle 0, identity matrix, pipeline empty.
// A stall on out_* holds the output register; the two inner stages keep
// filling, so up to three items are in flight before in_stall rises.
module axis_angle_vector_rotation_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aavr_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [aavr_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [aavr_pkg::VEC_W-1:0] in_vec_x,
  input  logic signed [aavr_pkg::VEC_W-1:0] in_vec_y,
  input  logic signed [aavr_pkg::VEC_W-1:0] in_vec_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [aavr_pkg::VEC_W-1:0] out_rot_x,
  output logic signed [aavr_pkg::VEC_W-1:0] out_rot_y,
  output logic signed [aavr_pkg::VEC_W-1:0] out_rot_z,
  output logic                             out_overflow
);
  import aavr_pkg::*;
  `include "axis_angle_vector_rotation_unit_assert.svh"

  mat_t mat;
  logic busy;
  logic v1_r, v2_r, ov_r;
  logic o_adv, s2_adv, s1_adv, accept;
  lane_ctl_t ctl;
  logic signed [VEC_W-1:0] rx, ry, rz;
  logic fx, fy, fz;
  logic signed [VEC_W-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic ovf_r;

  aavr_trig #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .mat(mat), .busy(busy)
  );

  assign o_adv = !ov_r || !out_stall;
  assign s2_adv = !v2_r || o_adv;
  assign s1_adv = !v1_r || s2_adv;
  assign in_stall = busy || !s1_adv;
  assign accept = in_valid && !in_stall;
  assign ctl.adv1 = s1_adv;
  assign ctl.adv2 = s2_adv;

  aavr_lane u_lane_x (.clk(clk), .ctl(ctl), .m0(mat[0]), .m1(mat[1]), .m2(mat[2]),
    .v0(in_vec_x), .v1(in_vec_y), .v2(in_vec_z), .res(rx), .ovf(fx));
  aavr_lane u_lane_y (.clk(clk), .ctl(ctl), .m0(mat[3]), .m1(mat[4]), .m2(mat[5]),
    .v0(in_vec_x), .v1(in_vec_y), .v2(in_vec_z), .res(ry), .ovf(fy));
  aavr_lane u_lane_z (.clk(clk), .ctl(ctl), .m0(mat[6]), .m1(mat[7]), .m2(mat[8]),
    .v0(in_vec_x), .v1(in_vec_y), .v2(in_vec_z), .res(rz), .ovf(fz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (s1_adv) v1_r <= accept;
      if (s2_adv) v2_r <= v1_r;
      if (o_adv) ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && v2_r) begin
      rot_x_r <= rx;
      rot_y_r <= ry;
      rot_z_r <= rz;
      ovf_r <= fx || fy || fz;
    end
  end

  assign out_valid = ov_r;
  assign out_rot_x = rot_x_r;
  assign out_rot_y = rot_y_r;
  assign out_rot_z = rot_z_r;
  assign out_overflow = ovf_r;

  `AAVR_ASSERT_NXT(a_cfg_stalls, clk, rst_n, cfg_we && (cfg_addr == REG_ANGLE || cfg_addr == REG_AXIS_X || cfg_addr == REG_AXIS_Y || cfg_addr == REG_AXIS_Z), in_stall)
  `AAVR_ASSERT_NXT(a_accept_fills, clk, rst_n, accept, v1_r)
  `AAVR_ASSERT_IMP(a_ovf_sat, clk, rst_n, out_valid && out_overflow, rot_x_r == 32'sh7fffffff || rot_x_r == 32'sh80000000 || rot_y_r == 32'sh7fffffff || rot_y_r == 32'sh80000000 || rot_z_r == 32'sh7fffffff || rot_z_r == 32'sh80000000)
endmodule
